### rtl/temp_sensor_compensate_average_assert.svh
// Assertion macros shared by the temperature compensation and averaging block.
`ifndef TEMP_SENSOR_COMPENSATE_AVERAGE_ASSERT_SVH
`define TEMP_SENSOR_COMPENSATE_AVERAGE_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define TSCA_ASSERT_HOLDS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define TSCA_ASSERT_THEN(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define TSCA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/tsca_pkg.sv
// Types and constants of the temperature compensation and averaging block.
`timescale 1ns / 1ps

package tsca_pkg;

	// Field and datapath widths.
	localparam int RAW_W      = 20;
	localparam int CAL_W      = 16;
	localparam int DIFF_W     = 21;
	localparam int DD_W       = 41;
	localparam int DD_LO_W    = 21;
	localparam int MUL_W      = 32;
	localparam int PROD_W     = 64;
	localparam int ACC_W      = 58;
	localparam int Q_W        = 24;
	localparam int SUM_W      = 31;
	localparam int TENTHS_W   = 11;
	localparam int DIGIT_W    = 4;
	localparam int AVG_T_W    = 10;
	localparam int AVG_W_W    = 19;
	localparam int CFG_IDX_W  = 2;

	// Shift amounts of the compensation and averaging steps.
	localparam int T2_SHIFT    = 20;
	localparam int NUM_SHIFT   = 28;
	localparam int DIV5_SHIFT  = 33;
	localparam int RECIP_SHIFT = 26;
	localparam int Q_FRAC      = 16;

	// Default number of samples averaged.
	localparam int SAMPLE_COUNT_DEF = 8;

	// Division by five: the dividend is biased positive by a multiple of five.
	localparam logic [SUM_W-1:0]        DIV5_BIAS  = SUM_W'(5 * (2 ** 27));
	localparam logic signed [MUL_W-1:0] DIV5_QBIAS = MUL_W'(2 ** 27);
	localparam logic signed [MUL_W-1:0] DIV5_RECIP = MUL_W'(1717986919);

	// Clamp limits in Q8.16.
	localparam logic signed [MUL_W-1:0] T_MIN = -MUL_W'(40 * 65536);
	localparam logic signed [MUL_W-1:0] T_MAX = MUL_W'(85 * 65536);

	// Rounding constant of 0.05 degree for one value scaled by ten.
	localparam logic [26:0] HALF_TENTH = 27'd32768;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_CALIB_T1    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CALIB_T2    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CALIB_T3    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_OFFSET = 2'd3;

	// Sequencer states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL_DD,
		S_MUL_T2,
		S_MUL_LO,
		S_MUL_HI,
		S_ACC_HI,
		S_DIV5,
		S_CLAMP,
		S_AVG_MUL,
		S_DIGITS,
		S_FINISH
	} state_t;

	// Operands handed to the shared multiplier.
	typedef struct packed {
		logic                    en;
		logic signed [MUL_W-1:0] a;
		logic signed [MUL_W-1:0] b;
	} mul_op_t;

	// Average as sign and three decimal digits.
	typedef struct packed {
		logic               neg;
		logic [DIGIT_W-1:0] tens;
		logic [DIGIT_W-1:0] units;
		logic [DIGIT_W-1:0] decimal;
	} avg_digits_t;

endpackage

### rtl/tsca_mul.sv
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps

module tsca_mul (
	input  logic                                   clk,
	input  tsca_pkg::mul_op_t                      op,
	output logic signed [tsca_pkg::PROD_W-1:0]     prod_q
);

	// Product register, loaded whenever the sequencer issues operands.
	always_ff @(posedge clk) begin
		if (op.en) begin
			prod_q <= tsca_pkg::PROD_W'(op.a) * tsca_pkg::PROD_W'(op.b);
		end
	end

endmodule

### rtl/tsca_digits.sv
// Splits the average in tenths into sign and three decimal digits.
`timescale 1ns / 1ps

module tsca_digits (
	input  logic [tsca_pkg::AVG_T_W-1:0] avg_tenths,
	input  logic                         sum_neg,
	output tsca_pkg::avg_digits_t        digits
);

	logic [17:0] prod_t;
	logic [6:0]  whole;
	logic [14:0] prod_w;
	logic [3:0]  tens;
	logic [9:0]  dec_full;
	logic [6:0]  units_full;

	// Division by ten through the reciprocal 205/2048, exact below 1029.
	always_comb begin
		prod_t     = 18'(avg_tenths) * 18'd205;
		whole      = prod_t[17:11];
		prod_w     = 15'(whole) * 15'd205;
		tens       = prod_w[14:11];
		dec_full   = avg_tenths - 10'(whole) * 10'd10;
		units_full = whole - 7'(tens) * 7'd10;

		digits.neg     = sum_neg && (avg_tenths != '0);
		digits.tens    = tens;
		digits.units   = units_full[3:0];
		digits.decimal = dec_full[3:0];
	end

endmodule

### rtl/temp_sensor_compensate_average.sv
// Top level of the temperature compensation and averaging block.
`timescale 1ns / 1ps
`include "temp_sensor_compensate_average_assert.svh"

// Each raw reading is accepted while idle and steps through the multiply,
// accumulate, division and clamp states before the next is accepted; one that
// finds SAMPLE_COUNT samples stored also takes the averaging states, reports
// the average and restarts the store. A stalled output holds the finish state.
// One 32x32 signed multiplier serves d*d, d*T2, both halves of d*d*T3, the
// division by five and the division of the running sum by SAMPLE_COUNT. One
// result item leaves for every input item; calibration registers are taken
// at any time with no wait states and must only change while idle.
module temp_sensor_compensate_average #(
	parameter int SAMPLE_COUNT = tsca_pkg::SAMPLE_COUNT_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// Configuration write channel.
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [tsca_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [tsca_pkg::CAL_W-1:0]              cfg_data,
	// Input channel.
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic [tsca_pkg::RAW_W-1:0]              raw_temperature,
	// Output channel.
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [tsca_pkg::TENTHS_W-1:0]    current_tenths,
	output logic                                    avg_ready,
	output logic                                    avg_negative,
	output logic [tsca_pkg::DIGIT_W-1:0]            avg_tens,
	output logic [tsca_pkg::DIGIT_W-1:0]            avg_units,
	output logic [tsca_pkg::DIGIT_W-1:0]            avg_decimal
);

	localparam int CNT_W = $clog2(SAMPLE_COUNT + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(SAMPLE_COUNT);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
	localparam logic signed [tsca_pkg::MUL_W-1:0] RECIP_N =
		tsca_pkg::MUL_W'((2 ** tsca_pkg::RECIP_SHIFT + SAMPLE_COUNT - 1) / SAMPLE_COUNT);
	localparam logic [34:0] HALF_N = 35'(32768 * SAMPLE_COUNT);

	// Calibration registers.
	logic [tsca_pkg::CAL_W-1:0]        t1_q;
	logic signed [tsca_pkg::CAL_W-1:0] t2_q;
	logic signed [tsca_pkg::CAL_W-1:0] t3_q;
	logic signed [tsca_pkg::CAL_W-1:0] off_q;

	// Sequencer and datapath registers.
	tsca_pkg::state_t                   state_q, state_d;
	tsca_pkg::mul_op_t                  mul_op;
	logic signed [tsca_pkg::PROD_W-1:0] prod_q;
	logic signed [tsca_pkg::DIFF_W-1:0] d_q;
	logic [tsca_pkg::DD_W-1:0]          dd_q;
	logic signed [tsca_pkg::ACC_W-1:0]  acc_q;
	logic signed [tsca_pkg::Q_W-1:0]    v_q;
	logic [tsca_pkg::AVG_W_W-1:0]       w_q;
	logic                               neg_q;
	logic signed [tsca_pkg::SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]                   count_q;
	tsca_pkg::avg_digits_t              last_q;

	// Output registers.
	logic                                 out_valid_q;
	logic signed [tsca_pkg::TENTHS_W-1:0] cur_q;
	logic                                 avg_ready_q;
	tsca_pkg::avg_digits_t                out_digits_q;

	// Intermediate values.
	logic [tsca_pkg::SUM_W-1:0]          div5_y;
	logic signed [tsca_pkg::MUL_W-1:0]   comp_t;
	logic signed [tsca_pkg::MUL_W-1:0]   comp_clamped;
	logic [tsca_pkg::SUM_W-1:0]          sum_mag;
	logic [34:0]                         sum_scaled;
	logic [tsca_pkg::AVG_T_W-1:0]        avg_tenths;
	tsca_pkg::avg_digits_t               avg_digits;
	logic [tsca_pkg::Q_W-1:0]            v_mag;
	logic [26:0]                         v_scaled;
	logic [tsca_pkg::AVG_T_W-1:0]        cur_mag;
	logic signed [tsca_pkg::TENTHS_W-1:0] cur_val;
	logic                                full;
	logic                                fin_fire;

	assign cfg_ready = 1'b1;

	// Calibration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t1_q  <= '0;
			t2_q  <= '0;
			t3_q  <= '0;
			off_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				tsca_pkg::REG_CALIB_T1:    t1_q  <= cfg_data;
				tsca_pkg::REG_CALIB_T2:    t2_q  <= cfg_data;
				tsca_pkg::REG_CALIB_T3:    t3_q  <= cfg_data;
				tsca_pkg::REG_TEMP_OFFSET: off_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Shared multiplier.
	tsca_mul u_mul (
		.clk    (clk),
		.op     (mul_op),
		.prod_q (prod_q)
	);

	// Digit split of the average.
	assign avg_tenths = prod_q[tsca_pkg::RECIP_SHIFT +: tsca_pkg::AVG_T_W];

	tsca_digits u_digits (
		.avg_tenths (avg_tenths),
		.sum_neg    (neg_q),
		.digits     (avg_digits)
	);

	// Biased compensation numerator for the division by five.
	assign div5_y = {acc_q[tsca_pkg::ACC_W-1], acc_q[tsca_pkg::ACC_W-1:tsca_pkg::NUM_SHIFT]}
		+ tsca_pkg::DIV5_BIAS;

	// Quotient, offset and clamp of the compensated value.
	always_comb begin
		comp_t = $signed({1'b0, prod_q[tsca_pkg::PROD_W-1:tsca_pkg::DIV5_SHIFT]})
			- tsca_pkg::DIV5_QBIAS
			+ tsca_pkg::MUL_W'($signed({off_q, 8'b0}));
		if (comp_t < tsca_pkg::T_MIN) begin
			comp_clamped = tsca_pkg::T_MIN;
		end else if (comp_t > tsca_pkg::T_MAX) begin
			comp_clamped = tsca_pkg::T_MAX;
		end else begin
			comp_clamped = comp_t;
		end
	end

	// Ten times the sum magnitude, rounded and scaled down to whole tenths times N.
	always_comb begin
		sum_mag    = sum_q[tsca_pkg::SUM_W-1] ? tsca_pkg::SUM_W'(-sum_q) : sum_q;
		sum_scaled = {1'b0, sum_mag, 3'b0} + {3'b0, sum_mag, 1'b0} + HALF_N;
	end

	// Current value in tenths, rounded on the magnitude.
	always_comb begin
		v_mag    = v_q[tsca_pkg::Q_W-1] ? tsca_pkg::Q_W'(-v_q) : v_q;
		v_scaled = {v_mag[23:0], 3'b0} + {2'b0, v_mag[23:0], 1'b0} + tsca_pkg::HALF_TENTH;
		cur_mag  = v_scaled[tsca_pkg::Q_FRAC +: tsca_pkg::AVG_T_W];
		cur_val  = v_q[tsca_pkg::Q_W-1] ? -tsca_pkg::TENTHS_W'(cur_mag)
			: tsca_pkg::TENTHS_W'(cur_mag);
	end

	assign full     = (count_q == CNT_FULL);
	assign fin_fire = (state_q == tsca_pkg::S_FINISH) && (!out_valid_q || out_ready);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tsca_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and multiplier operands.
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		mul_op.en = 1'b0;
		mul_op.a  = '0;
		mul_op.b  = '0;
		unique case (state_q)
			tsca_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = tsca_pkg::S_MUL_DD;
				end
			end
			tsca_pkg::S_MUL_DD: begin
				mul_op.en = 1'b1;
				mul_op.a  = tsca_pkg::MUL_W'(d_q);
				mul_op.b  = tsca_pkg::MUL_W'(d_q);
				state_d   = tsca_pkg::S_MUL_T2;
			end
			tsca_pkg::S_MUL_T2: begin
				mul_op.en = 1'b1;
				mul_op.a  = tsca_pkg::MUL_W'(d_q);
				mul_op.b  = tsca_pkg::MUL_W'(t2_q);
				state_d   = tsca_pkg::S_MUL_LO;
			end
			tsca_pkg::S_MUL_LO: begin
				mul_op.en = 1'b1;
				mul_op.a  = tsca_pkg::MUL_W'(dd_q[tsca_pkg::DD_LO_W-1:0]);
				mul_op.b  = tsca_pkg::MUL_W'(t3_q);
				state_d   = tsca_pkg::S_MUL_HI;
			end
			tsca_pkg::S_MUL_HI: begin
				mul_op.en = 1'b1;
				mul_op.a  = tsca_pkg::MUL_W'(dd_q[tsca_pkg::DD_W-1:tsca_pkg::DD_LO_W]);
				mul_op.b  = tsca_pkg::MUL_W'(t3_q);
				state_d   = tsca_pkg::S_ACC_HI;
			end
			tsca_pkg::S_ACC_HI: begin
				state_d = tsca_pkg::S_DIV5;
			end
			tsca_pkg::S_DIV5: begin
				mul_op.en = 1'b1;
				mul_op.a  = $signed({1'b0, div5_y});
				mul_op.b  = tsca_pkg::DIV5_RECIP;
				state_d   = tsca_pkg::S_CLAMP;
			end
			tsca_pkg::S_CLAMP: begin
				state_d = full ? tsca_pkg::S_AVG_MUL : tsca_pkg::S_FINISH;
			end
			tsca_pkg::S_AVG_MUL: begin
				mul_op.en = 1'b1;
				mul_op.a  = tsca_pkg::MUL_W'(w_q);
				mul_op.b  = RECIP_N;
				state_d   = tsca_pkg::S_DIGITS;
			end
			tsca_pkg::S_DIGITS: begin
				state_d = tsca_pkg::S_FINISH;
			end
			tsca_pkg::S_FINISH: begin
				if (!out_valid_q || out_ready) begin
					state_d = tsca_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = tsca_pkg::S_IDLE;
			end
		endcase
	end

	// Datapath registers stepped by the sequencer.
	always_ff @(posedge clk) begin
		unique case (state_q)
			tsca_pkg::S_IDLE: begin
				d_q <= tsca_pkg::DIFF_W'(raw_temperature) - tsca_pkg::DIFF_W'({t1_q, 4'b0});
			end
			tsca_pkg::S_MUL_T2: begin
				dd_q <= prod_q[tsca_pkg::DD_W-1:0];
			end
			tsca_pkg::S_MUL_LO: begin
				acc_q <= {prod_q[tsca_pkg::ACC_W-tsca_pkg::T2_SHIFT-1:0],
					{tsca_pkg::T2_SHIFT{1'b0}}};
			end
			tsca_pkg::S_MUL_HI: begin
				acc_q <= acc_q + prod_q[tsca_pkg::ACC_W-1:0];
			end
			tsca_pkg::S_ACC_HI: begin
				acc_q <= acc_q + {prod_q[tsca_pkg::ACC_W-tsca_pkg::DD_LO_W-1:0],
					{tsca_pkg::DD_LO_W{1'b0}}};
			end
			tsca_pkg::S_CLAMP: begin
				v_q   <= comp_clamped[tsca_pkg::Q_W-1:0];
				w_q   <= sum_scaled[34:tsca_pkg::Q_FRAC];
				neg_q <= sum_q[tsca_pkg::SUM_W-1];
			end
			default: ;
		endcase
	end

	// Running sum, sample count and the last reported average.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
			last_q  <= '0;
		end else begin
			if (state_q == tsca_pkg::S_DIGITS) begin
				last_q <= avg_digits;
			end
			if (fin_fire) begin
				if (full) begin
					sum_q   <= tsca_pkg::SUM_W'(v_q);
					count_q <= CNT_ONE;
				end else begin
					sum_q   <= sum_q + tsca_pkg::SUM_W'(v_q);
					count_q <= count_q + CNT_ONE;
				end
			end
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload, loaded as the sequencer finishes an item.
	always_ff @(posedge clk) begin
		if (fin_fire) begin
			cur_q        <= cur_val;
			avg_ready_q  <= full;
			out_digits_q <= last_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign current_tenths = cur_q;
	assign avg_ready      = avg_ready_q;
	assign avg_negative   = out_digits_q.neg;
	assign avg_tens       = out_digits_q.tens;
	assign avg_units      = out_digits_q.units;
	assign avg_decimal    = out_digits_q.decimal;

	// Checks on the sequencer and the result values.
	`TSCA_ASSERT_HOLDS(a_count_bound, count_q <= CNT_FULL, "sample count beyond store depth")
	`TSCA_ASSERT_NEXT(a_avg_restart, fin_fire && full,
		out_valid && avg_ready && (count_q == CNT_ONE), "average item did not restart store")
	`TSCA_ASSERT_THEN(a_neg_nonzero, out_valid && avg_negative,
		(avg_tens != '0) || (avg_units != '0) || (avg_decimal != '0),
		"negative sign on a zero average")
	`TSCA_ASSERT_THEN(a_tenths_range, out_valid,
		(current_tenths >= -11'sd400) && (current_tenths <= 11'sd850),
		"current temperature outside clamp range")

endmodule

### verif/temp_sensor_compensate_average_tb.sv
// Self-checking testbench of the temperature compensation and averaging block.
`timescale 1ns / 1ps

module temp_sensor_compensate_average_tb;

	localparam int SAMPLES = 8;
	localparam int PHASE_ITEMS = 125;
	localparam int RAND_PHASES = 9;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 12;
	localparam int STALL_LIMIT = 2000;
	localparam int PRINT_CAP = 40;
	localparam longint COMP_DEN = 64'd5120 * 64'd262144;
	localparam longint Q_MIN = -40 * 65536;
	localparam longint Q_MAX = 85 * 65536;
	// Raw span that moves the reading through the full clamp range for T2 = 1.
	localparam longint FULL_SWING = 64'd125 * 64'd1280 * 64'd65536;

	// One result item as the block reports it.
	typedef struct packed {
		logic signed [tsca_pkg::TENTHS_W-1:0] tenths;
		logic                                 avg_ready;
		tsca_pkg::avg_digits_t                avg;
	} reading_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [tsca_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [tsca_pkg::CAL_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [tsca_pkg::RAW_W-1:0] raw_temperature = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [tsca_pkg::TENTHS_W-1:0] current_tenths;
	logic avg_ready;
	logic avg_negative;
	logic [tsca_pkg::DIGIT_W-1:0] avg_tens;
	logic [tsca_pkg::DIGIT_W-1:0] avg_units;
	logic [tsca_pkg::DIGIT_W-1:0] avg_decimal;

	// Calibration copy and averaging state of the predictor.
	logic [tsca_pkg::CAL_W-1:0] cal_t1 = '0;
	logic signed [tsca_pkg::CAL_W-1:0] cal_t2 = '0;
	logic signed [tsca_pkg::CAL_W-1:0] cal_t3 = '0;
	logic signed [tsca_pkg::CAL_W-1:0] cal_offset = '0;
	int store_count = 0;
	longint store_sum = 0;
	tsca_pkg::avg_digits_t last_digits = '0;

	logic [tsca_pkg::RAW_W-1:0] pending_raw[$];
	reading_t expected_readings[$];
	int mismatches = 0;
	logic raw_taken = 1'b0;
	logic calm = 1'b0;
	logic hold_toggle = 1'b0;
	logic hold_seen = 1'b0;
	int hold_left = 0;
	int send_gap = 0;
	int recv_gap = 0;
	int idle_cycles = 0;

	temp_sensor_compensate_average #(
		.SAMPLE_COUNT(SAMPLES)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.raw_temperature(raw_temperature),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.current_tenths(current_tenths),
		.avg_ready(avg_ready),
		.avg_negative(avg_negative),
		.avg_tens(avg_tens),
		.avg_units(avg_units),
		.avg_decimal(avg_decimal)
	);

	always #5 clk = ~clk;

	// Compensates one raw reading and advances the running average.
	function automatic reading_t predict_reading(input logic [tsca_pkg::RAW_W-1:0] raw);
		longint d;
		longint num;
		longint v;
		longint mag;
		longint r;
		longint t;
		reading_t res;
		d = longint'(raw) - 16 * longint'(cal_t1);
		num = d * longint'(cal_t2) * 1048576 + d * d * longint'(cal_t3);
		v = num / COMP_DEN;
		if ((num % COMP_DEN) != 0 && num < 0)
			v = v - 1;
		v = v + longint'(cal_offset) * 256;
		if (v < Q_MIN)
			v = Q_MIN;
		if (v > Q_MAX)
			v = Q_MAX;
		// Round the magnitude to tenths, then put the sign back.
		mag = (v < 0) ? -v : v;
		r = (mag * 10 + 32768) / 65536;
		res.tenths = tsca_pkg::TENTHS_W'((v < 0) ? -r : r);
		if (store_count < SAMPLES) begin
			store_sum = store_sum + v;
			store_count = store_count + 1;
			res.avg_ready = 1'b0;
		end else begin
			// A full store: report the mean and restart with this sample.
			mag = (store_sum < 0) ? -store_sum : store_sum;
			t = (mag * 10 + 64'd32768 * SAMPLES) / (64'd65536 * SAMPLES);
			last_digits.neg = (store_sum < 0) && (t != 0);
			last_digits.tens = tsca_pkg::DIGIT_W'((t / 100) % 10);
			last_digits.units = tsca_pkg::DIGIT_W'((t / 10) % 10);
			last_digits.decimal = tsca_pkg::DIGIT_W'(t % 10);
			store_sum = v;
			store_count = 1;
			res.avg_ready = 1'b1;
		end
		res.avg = last_digits;
		return res;
	endfunction

	// Picks a raw reading, mostly in a span around the reference raw value that covers the clamp range.
	function automatic logic [tsca_pkg::RAW_W-1:0] pick_raw();
		longint spread;
		longint mag_t2;
		longint val;
		if ($urandom_range(0, 9) < 3)
			return tsca_pkg::RAW_W'($urandom_range(0, 20'hFFFFF));
		mag_t2 = (cal_t2 < 0) ? -longint'(cal_t2) : longint'(cal_t2);
		if (mag_t2 < 64)
			mag_t2 = 64;
		spread = FULL_SWING / mag_t2;
		if (spread > 20'hFFFFF)
			spread = 20'hFFFFF;
		val = 16 * longint'(cal_t1) + longint'($urandom_range(0, int'(2 * spread))) - spread;
		if (val < 0)
			val = 0;
		if (val > 20'hFFFFF)
			val = 20'hFFFFF;
		return tsca_pkg::RAW_W'(val);
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		if (mismatches < PRINT_CAP)
			$display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		mismatches = mismatches + 1;
	endtask

	// Writes all four calibration registers; the block must be idle.
	task automatic program_calibration(input logic [15:0] t1, input logic [15:0] t2,
		input logic [15:0] t3, input logic [15:0] off);
		logic [tsca_pkg::CFG_IDX_W-1:0] idx;
		logic [tsca_pkg::CAL_W-1:0] val;
		for (int r = 0; r < 4; r++) begin
			case (r)
				0: begin
					idx = tsca_pkg::REG_CALIB_T1;
					val = t1;
				end
				1: begin
					idx = tsca_pkg::REG_CALIB_T2;
					val = t2;
				end
				2: begin
					idx = tsca_pkg::REG_CALIB_T3;
					val = t3;
				end
				default: begin
					idx = tsca_pkg::REG_TEMP_OFFSET;
					val = off;
				end
			endcase
			@(negedge clk);
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data <= val;
			do @(posedge clk); while (!cfg_ready);
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Waits until every queued item went in and every result came out.
	task automatic wait_drained();
		while (pending_raw.size() != 0 || in_valid || expected_readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Sender: presents queued readings, with random gaps between items.
	always @(negedge clk) begin
		if (arst_n && (!in_valid || raw_taken)) begin
			if (send_gap != 0) begin
				send_gap = send_gap - 1;
				in_valid <= 1'b0;
			end else if (!calm && $urandom_range(0, 11) == 0) begin
				send_gap = $urandom_range(1, 18) - 1;
				in_valid <= 1'b0;
			end else if (pending_raw.size() != 0) begin
				in_valid <= 1'b1;
				raw_temperature <= pending_raw.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stall bursts, plus one long hold-off on request.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_toggle != hold_seen) begin
				hold_seen = hold_toggle;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left = hold_left - 1;
				out_ready <= 1'b0;
			end else if (recv_gap != 0) begin
				recv_gap = recv_gap - 1;
				out_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				recv_gap = $urandom_range(1, 18) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Monitor: tracks register writes, predicts accepted items, checks results.
	always @(posedge clk) begin
		reading_t want;
		reading_t got;
		raw_taken <= in_valid && in_ready;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					tsca_pkg::REG_CALIB_T1: cal_t1 = cfg_data;
					tsca_pkg::REG_CALIB_T2: cal_t2 = cfg_data;
					tsca_pkg::REG_CALIB_T3: cal_t3 = cfg_data;
					tsca_pkg::REG_TEMP_OFFSET: cal_offset = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				expected_readings.push_back(predict_reading(raw_temperature));
			if (out_valid && out_ready) begin
				got.tenths = current_tenths;
				got.avg_ready = avg_ready;
				got.avg.neg = avg_negative;
				got.avg.tens = avg_tens;
				got.avg.units = avg_units;
				got.avg.decimal = avg_decimal;
				if (expected_readings.size() == 0) begin
					report_mismatch("result with nothing pending", got.tenths, 0);
				end else begin
					want = expected_readings.pop_front();
					if (got.tenths !== want.tenths)
						report_mismatch("current_tenths", got.tenths, want.tenths);
					if (got.avg_ready !== want.avg_ready)
						report_mismatch("avg_ready", got.avg_ready, want.avg_ready);
					if (got.avg.neg !== want.avg.neg)
						report_mismatch("avg_negative", got.avg.neg, want.avg.neg);
					if (got.avg.tens !== want.avg.tens)
						report_mismatch("avg_tens", got.avg.tens, want.avg.tens);
					if (got.avg.units !== want.avg.units)
						report_mismatch("avg_units", got.avg.units, want.avg.units);
					if (got.avg.decimal !== want.avg.decimal)
						report_mismatch("avg_decimal", got.avg.decimal, want.avg.decimal);
				end
			end
		end
	end

	// Watchdog: ends the run when no channel moves an item for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles = idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("timeout: no item moved for %0d cycles", STALL_LIMIT);
				$display("temp_sensor_compensate_average regression: fail");
				$finish;
			end
		end
	end

	// Stimulus sequence.
	initial begin
		logic [15:0] t2;
		logic [15:0] off;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset calibration: both raw extremes compensate to zero.
		pending_raw.push_back(20'hFFFFF);
		pending_raw.push_back(20'h00000);
		wait_drained();

		// Typical calibration with a tiny negative offset: a reading at the
		// reference raw value rounds to zero, and so does the full-store mean.
		program_calibration(16'd27504, 16'd26435, -16'sd1000, 16'hFFFF);
		repeat (8) pending_raw.push_back(20'd440064);
		pending_raw.push_back(20'h00000);
		pending_raw.push_back(20'hFFFFF);
		repeat (4) pending_raw.push_back(20'd408328);
		wait_drained();

		// A quarter degree below zero sits exactly on the rounding tie.
		program_calibration(16'd27504, 16'd26435, -16'sd1000, -16'sd64);
		repeat (8) pending_raw.push_back(20'd440064);
		wait_drained();

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			case (ph)
				0: program_calibration(16'd27504, 16'd26435, -16'sd1000, -16'sd64);
				1: program_calibration(16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
				2: program_calibration(16'h0000, 16'h8000, 16'h8000, 16'h8000);
				3: program_calibration(16'h0000, 16'h7FFF, 16'h8000, 16'h0000);
				default: begin
					t2 = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
						16'($urandom_range(16000, 32767));
					off = ($urandom_range(0, 4) == 0) ? 16'($urandom) :
						16'(int'($urandom_range(0, 10239)) - 5120);
					program_calibration(16'($urandom), t2, 16'($urandom), off);
				end
			endcase
			calm = (ph == RAND_PHASES - 1);
			for (int n = 0; n < PHASE_ITEMS; n++)
				pending_raw.push_back(pick_raw());
			// Stall the output long enough that the block backs up its input.
			if (ph == 4)
				hold_toggle = ~hold_toggle;
			wait_drained();
		end

		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_readings.size() == 0) begin
			$display("temp_sensor_compensate_average regression: pass");
		end else begin
			$display("temp_sensor_compensate_average regression: fail");
		end
		$finish;
	end

endmodule

### temp_sensor_compensate_average.f
+incdir+rtl
rtl/tsca_pkg.sv
rtl/tsca_mul.sv
rtl/tsca_digits.sv
rtl/temp_sensor_compensate_average.sv
verif/temp_sensor_compensate_average_tb.sv
